### hdl/eth_ip_transport_header_parser_core_assert.svh
// assertion macros used by the header parser result module
`ifndef ETH_IP_TRANSPORT_HEADER_PARSER_CORE_ASSERT_SVH
`define ETH_IP_TRANSPORT_HEADER_PARSER_CORE_ASSERT_SVH

// same-cycle implication, held off during reset
`define ETHIPH_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("ethiph assertion failed");

// next-cycle implication, held off during reset
`define ETHIPH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("ethiph assertion failed");

`endif

### hdl/ethiph_pkg.sv
// package: constants and types of the ethernet / ip transport header parser
`timescale 1ns / 1ps
`default_nettype none
package ethiph_pkg;

  localparam int unsigned PARSE_DEPTH_DEF = 64;

  localparam logic [15:0] LINK_ETHERNET = 16'd1;
  localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETH_TYPE_IPV6 = 16'h86DD;
  localparam int unsigned MF_BIT_IDX    = 5;
  localparam int unsigned FRAG_HI_BITS  = 5;

  localparam int unsigned ETH_TYPE_POS = 12;
  localparam int unsigned IP_START     = 14;
  localparam int unsigned IPV4_HDR     = 20;
  localparam int unsigned IPV6_HDR     = 40;

  localparam logic [3:0] NIBBLE_V4 = 4'd4;
  localparam logic [3:0] NIBBLE_V6 = 4'd6;

  localparam logic [2:0] IP_VER_NONE = 3'd0;
  localparam logic [2:0] IP_VER_4    = 3'd4;
  localparam logic [2:0] IP_VER_6    = 3'd6;

  localparam logic [5:0] TP_OFFSET_V4   = 6'(IP_START + IPV4_HDR);
  localparam logic [5:0] TP_OFFSET_V6   = 6'(IP_START + IPV6_HDR);
  localparam logic [5:0] TP_OFFSET_NONE = 6'd0;

  // header bytes kept while a frame streams in
  typedef struct packed {
    logic [15:0] ethertype;
    logic [3:0]  version;
    logic [15:0] length;
    logic [7:0]  flags_hi;
    logic [7:0]  flags_lo;
    logic [7:0]  protocol;
    logic [15:0] port_one;
    logic [15:0] port_two;
  } frame_t;

endpackage
`default_nettype wire

### hdl/eth_ip_transport_header_parser_core.sv
// a result is registered and valid once its frame's last byte leaves the input register
// throughput: one byte per cycle except in a stall, set by the input register
// feeding capture; it stalls only when a last byte meets a result not yet taken
// reset: asynchronous, active low; clears the frame state and sets link type to ethernet
// top level of the ethernet / ip transport header parser
`timescale 1ns / 1ps
`default_nettype none
module eth_ip_transport_header_parser_core import ethiph_pkg::*; #(
  parameter int unsigned ParseDepth = PARSE_DEPTH_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic        [7:0]  data_byte_i,
  input  wire logic               last_byte_i,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic        [15:0] cfg_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic             [2:0]  ip_family_o,
  output logic             [7:0]  transport_protocol_o,
  output logic             [5:0]  transport_offset_o,
  output logic signed      [16:0] transport_length_o,
  output logic             [15:0] first_port_o,
  output logic             [15:0] second_port_o,
  output logic                    fragment_flag_o,
  output logic             [15:0] frag_len_o
);

  logic        s1_vld_q, s1_vld_d;
  logic [7:0]  s1_byte_q;
  logic        s1_last_q;
  logic [15:0] link_type_q;
  logic        s1_fire;
  logic        in_fire;
  frame_t      frame;

  // a non-last byte never needs the output slot
  assign s1_fire    = s1_vld_q && (!s1_last_q || !out_valid_o || out_ready_i);
  assign in_ready_o = !s1_vld_q || s1_fire;
  assign in_fire    = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    s1_vld_d = s1_vld_q;
    if (in_fire) begin
      s1_vld_d = 1'b1;
    end else if (s1_fire) begin
      s1_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q    <= 1'b0;
      link_type_q <= LINK_ETHERNET;
    end else begin
      s1_vld_q <= s1_vld_d;
      if (cfg_valid_i) begin
        link_type_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_byte_q <= data_byte_i;
      s1_last_q <= last_byte_i;
    end
  end

  ethiph_capture #(
    .ParseDepth(ParseDepth)
  ) u_capture (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (s1_fire),
    .data_byte_i(s1_byte_q),
    .last_byte_i(s1_last_q),
    .frame_o    (frame)
  );

  ethiph_result u_result (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .take_i              (s1_fire && s1_last_q),
    .frame_i             (frame),
    .link_type_i         (link_type_q),
    .out_ready_i         (out_ready_i),
    .out_valid_o         (out_valid_o),
    .ip_family_o         (ip_family_o),
    .transport_protocol_o(transport_protocol_o),
    .transport_offset_o  (transport_offset_o),
    .transport_length_o  (transport_length_o),
    .first_port_o        (first_port_o),
    .second_port_o       (second_port_o),
    .fragment_flag_o     (fragment_flag_o),
    .frag_len_o          (frag_len_o)
  );

endmodule
`default_nettype wire

### hdl/ethiph_capture.sv
// byte position counter and header field capture
`timescale 1ns / 1ps
`default_nettype none
module ethiph_capture import ethiph_pkg::*; #(
  parameter int unsigned ParseDepth = PARSE_DEPTH_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       fire_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       last_byte_i,
  output frame_t          frame_o
);

  localparam int unsigned PosW = $clog2(ParseDepth);
  localparam logic [PosW-1:0] PosMax    = PosW'(ParseDepth - 1);
  localparam logic [PosW-1:0] PosEthHi  = PosW'(ETH_TYPE_POS);
  localparam logic [PosW-1:0] PosEthLo  = PosW'(ETH_TYPE_POS + 1);
  localparam logic [PosW-1:0] PosVer    = PosW'(IP_START);
  localparam logic [PosW-1:0] PosV4LenH = PosW'(IP_START + 2);
  localparam logic [PosW-1:0] PosV4LenL = PosW'(IP_START + 3);
  localparam logic [PosW-1:0] PosV6LenH = PosW'(IP_START + 4);
  localparam logic [PosW-1:0] PosV6LenL = PosW'(IP_START + 5);
  localparam logic [PosW-1:0] PosFlagH  = PosW'(IP_START + 6);
  localparam logic [PosW-1:0] PosFlagL  = PosW'(IP_START + 7);
  localparam logic [PosW-1:0] PosV4Prot = PosW'(IP_START + 9);
  localparam logic [PosW-1:0] PosV6Prot = PosW'(IP_START + 6);
  localparam logic [PosW-1:0] PosTpV4   = PosW'(IP_START + IPV4_HDR);
  localparam logic [PosW-1:0] PosTpV6   = PosW'(IP_START + IPV6_HDR);

  logic [PosW-1:0] pos_q, pos_d;
  frame_t          frame_q, frame_d;
  logic            is_v4, is_v6;
  logic [PosW-1:0] tp_pos;

  always_comb begin
    frame_d = frame_q;
    pos_d   = pos_q;
    // protocol decisions use the ethertype as it stood before this byte
    is_v4  = (frame_q.ethertype == ETH_TYPE_IPV4);
    is_v6  = (frame_q.ethertype == ETH_TYPE_IPV6);
    tp_pos = is_v4 ? PosTpV4 : PosTpV6;
    if (pos_q != PosMax) begin
      pos_d = pos_q + PosW'(1);
      if (pos_q == PosEthHi) frame_d.ethertype[15:8] = data_byte_i;
      if (pos_q == PosEthLo) frame_d.ethertype[7:0]  = data_byte_i;
      if (pos_q == PosVer)   frame_d.version         = data_byte_i[7:4];
      if (is_v4) begin
        if (pos_q == PosV4LenH) frame_d.length[15:8] = data_byte_i;
        if (pos_q == PosV4LenL) frame_d.length[7:0]  = data_byte_i;
        if (pos_q == PosFlagH)  frame_d.flags_hi     = data_byte_i;
        if (pos_q == PosFlagL)  frame_d.flags_lo     = data_byte_i;
        if (pos_q == PosV4Prot) frame_d.protocol     = data_byte_i;
      end else if (is_v6) begin
        if (pos_q == PosV6LenH) frame_d.length[15:8] = data_byte_i;
        if (pos_q == PosV6LenL) frame_d.length[7:0]  = data_byte_i;
        if (pos_q == PosV6Prot) frame_d.protocol     = data_byte_i;
      end
      if (is_v4 || is_v6) begin
        if (pos_q == tp_pos)                frame_d.port_one[15:8] = data_byte_i;
        if (pos_q == tp_pos + PosW'(1))     frame_d.port_one[7:0]  = data_byte_i;
        if (pos_q == tp_pos + PosW'(2))     frame_d.port_two[15:8] = data_byte_i;
        if (pos_q == tp_pos + PosW'(3))     frame_d.port_two[7:0]  = data_byte_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      frame_q <= '0;
    end else if (fire_i) begin
      if (last_byte_i) begin
        // frame done: start clean for the next one
        pos_q   <= '0;
        frame_q <= '0;
      end else begin
        pos_q   <= pos_d;
        frame_q <= frame_d;
      end
    end
  end

  assign frame_o = frame_d;

endmodule
`default_nettype wire

### hdl/ethiph_result.sv
// result decode and output register
`timescale 1ns / 1ps
`default_nettype none
`include "eth_ip_transport_header_parser_core_assert.svh"
module ethiph_result import ethiph_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               take_i,
  input  wire frame_t             frame_i,
  input  wire logic        [15:0] link_type_i,
  input  wire logic               out_ready_i,
  output logic                    out_valid_o,
  output logic             [2:0]  ip_family_o,
  output logic             [7:0]  transport_protocol_o,
  output logic             [5:0]  transport_offset_o,
  output logic signed      [16:0] transport_length_o,
  output logic             [15:0] first_port_o,
  output logic             [15:0] second_port_o,
  output logic                    fragment_flag_o,
  output logic             [15:0] frag_len_o
);

  logic               vld_q, vld_d;
  logic [2:0]         ver_d;
  logic [7:0]         proto_d;
  logic [5:0]         offs_d;
  logic signed [16:0] tlen_d;
  logic [15:0]        p1_d, p2_d;
  logic               fflag_d;
  logic [15:0]        flen_d;

  always_comb begin
    ver_d   = IP_VER_NONE;
    proto_d = '0;
    offs_d  = TP_OFFSET_NONE;
    tlen_d  = '0;
    p1_d    = '0;
    p2_d    = '0;
    fflag_d = 1'b0;
    flen_d  = '0;
    if (link_type_i == LINK_ETHERNET) begin
      if (frame_i.ethertype == ETH_TYPE_IPV4 && frame_i.version == NIBBLE_V4) begin
        ver_d   = IP_VER_4;
        fflag_d = frame_i.flags_hi[MF_BIT_IDX];
        flen_d  = fflag_d ? {3'b000, frame_i.flags_hi[FRAG_HI_BITS-1:0], frame_i.flags_lo}
                          : frame_i.length;
        offs_d  = TP_OFFSET_V4;
        proto_d = frame_i.protocol;
        tlen_d  = $signed({1'b0, frame_i.length}) - 17'sd20;
      end else if (frame_i.ethertype == ETH_TYPE_IPV6 && frame_i.version == NIBBLE_V6) begin
        ver_d   = IP_VER_6;
        offs_d  = TP_OFFSET_V6;
        proto_d = frame_i.protocol;
        tlen_d  = $signed({1'b0, frame_i.length});
      end
      if (tlen_d != 17'sd0) begin
        p1_d = frame_i.port_one;
        p2_d = frame_i.port_two;
      end
    end
  end

  always_comb begin
    vld_d = vld_q;
    if (take_i) begin
      vld_d = 1'b1;
    end else if (out_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      ip_family_o          <= ver_d;
      transport_protocol_o <= proto_d;
      transport_offset_o   <= offs_d;
      transport_length_o   <= tlen_d;
      first_port_o         <= p1_d;
      second_port_o        <= p2_d;
      fragment_flag_o      <= fflag_d;
      frag_len_o           <= flen_d;
    end
  end

  assign out_valid_o = vld_q;

  `ETHIPH_ASSERT_NEXT(a_take_gives_result, clk_i, rst_ni, take_i, out_valid_o)
  `ETHIPH_ASSERT_NOW(a_no_ip_all_zero, clk_i, rst_ni,
    out_valid_o && ip_family_o == IP_VER_NONE,
    transport_offset_o == TP_OFFSET_NONE && transport_length_o == 17'sd0)
  `ETHIPH_ASSERT_NOW(a_ports_need_length, clk_i, rst_ni,
    out_valid_o && (first_port_o != 16'd0 || second_port_o != 16'd0),
    transport_length_o != 17'sd0)
  `ETHIPH_ASSERT_NOW(a_fragment_only_v4, clk_i, rst_ni,
    out_valid_o && fragment_flag_o, ip_family_o == IP_VER_4)

endmodule
`default_nettype wire
